>>> rtl/dual_byte_queue_frame_pop_core_defines.svh
// Assertion macros shared by the dual byte queue RTL
`ifndef DUAL_BYTE_QUEUE_FRAME_POP_CORE_DEFINES_SVH
`define DUAL_BYTE_QUEUE_FRAME_POP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DBQFP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DBQFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DBQFP_ASSERT(lbl, ante, cons, msg)
`define DBQFP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/dbqfp_pkg.sv
// Types and constants for the dual byte queue with frame pop
`timescale 1ns / 1ps
package dbqfp_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int FRAME_BYTES = 11;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 9;
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W  = IDX_W + 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = ((FILL_W > LEN_W) ? FILL_W : LEN_W) + 1;
  localparam int RES_W   = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  typedef enum logic [1:0] {
    STAT_FRAME = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_ERROR = 2'd2
  } dbqfp_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } dbqfp_state_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } dbqfp_op_t;

  typedef struct packed {
    logic          push;
    logic          pop_start;
    logic          rd_issue;
    logic          out_load;
    dbqfp_status_t out_kind;
    logic          out_last;
  } dbqfp_cmd_t;

  typedef struct packed {
    logic empty;
    logic refuse;
  } dbqfp_stat_t;

endpackage

>>> rtl/dbqfp_ifs.sv
// Valid/ready channel interfaces for the input and result items
`timescale 1ns / 1ps
interface dbqfp_in_if;
  import dbqfp_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic              queue_sel;
  logic [BYTE_W-1:0] data_byte;
  logic              block_start;
  logic              block_last;
  logic [LEN_W-1:0]  block_length;

  modport source (output valid, command, queue_sel, data_byte, block_start,
                  block_last, block_length, input ready);
  modport sink (input valid, command, queue_sel, data_byte, block_start,
                block_last, block_length, output ready);
endinterface

interface dbqfp_out_if;
  import dbqfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [BYTE_W-1:0] frame_byte;
  logic              from_queue;
  logic              last;

  modport source (output valid, status, frame_byte, from_queue, last, input ready);
  modport sink (input valid, status, frame_byte, from_queue, last, output ready);
endinterface

>>> rtl/dual_byte_queue_frame_pop_core.sv
// Top level of the dual byte queue with prioritized frame pop
`timescale 1ns / 1ps
// Two byte FIFOs, A (high priority) and B, of QUEUE_DEPTH bytes each in one
// shared store. Pushes arrive in blocks whose declared length is checked on
// the first byte; a block that would not fit is dropped whole, and an open
// block locks its queue. A pop serves A if it holds data, else B, and gives
// FRAME_BYTES frame bytes (last on the final one) when the queue is unlocked
// and its count is a whole number of frames; otherwise it gives one empty or
// error item. Each frame byte passes through the registered read port of the
// byte store and then through the result register, and output stalls hold a
// frame pop back. Input items are taken only between pops.
module dual_byte_queue_frame_pop_core (
  input logic        clk,
  input logic        rst_n,
  dbqfp_in_if.sink   in_ch,
  dbqfp_out_if.source out_ch
);
  import dbqfp_pkg::*;

  dbqfp_cmd_t  cmd;
  dbqfp_stat_t stat;

  dbqfp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .stat       (stat),
    .cmd        (cmd)
  );

  dbqfp_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .queue_sel    (in_ch.queue_sel),
    .data_byte    (in_ch.data_byte),
    .block_start  (in_ch.block_start),
    .block_last   (in_ch.block_last),
    .block_length (in_ch.block_length),
    .stat         (stat),
    .status       (out_ch.status),
    .frame_byte   (out_ch.frame_byte),
    .from_queue   (out_ch.from_queue),
    .last         (out_ch.last)
  );

endmodule

>>> rtl/dbqfp_ctrl.sv
// Controller: item handshake, pop sequencing and output valid
`timescale 1ns / 1ps
`include "dual_byte_queue_frame_pop_core_defines.svh"
module dbqfp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_command,
  output logic                   in_ready,
  input  logic                   out_ready,
  output logic                   out_valid,
  input  dbqfp_pkg::dbqfp_stat_t stat,
  output dbqfp_pkg::dbqfp_cmd_t  cmd
);
  import dbqfp_pkg::*;

  dbqfp_state_t     state_r, state_nxt;
  logic [RES_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             acc;
  logic             pop_go;
  logic             frame_end;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign acc       = in_valid && in_ready;
  assign pop_go    = acc && (in_command == CMD_POP) && !stat.empty && !stat.refuse;
  assign frame_end = (cnt_r == RES_W'(FRAME_BYTES - 1));
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (pop_go) state_nxt = S_READ;
      S_READ: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) state_nxt = frame_end ? S_IDLE : S_READ;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_kind = STAT_FRAME;
    case (state_r)
      S_IDLE: begin
        if (acc && (in_command == CMD_PUSH)) cmd.push = 1'b1;
        if (acc && (in_command == CMD_POP)) begin
          if (stat.empty) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = STAT_EMPTY;
            cmd.out_last = 1'b1;
          end else if (stat.refuse) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = STAT_ERROR;
            cmd.out_last = 1'b1;
          end else begin
            cmd.pop_start = 1'b1;
          end
        end
      end
      S_READ: cmd.rd_issue = 1'b1;
      S_EMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = frame_end;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.pop_start) cnt_nxt = '0;
    else if ((state_r == S_EMIT) && cmd.out_load) cnt_nxt = cnt_r + RES_W'(1);
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `DBQFP_ASSERT(a_load_free, cmd.out_load, out_free, "result loaded over a pending item")
  `DBQFP_ASSERT_NXT(a_read_emit, state_r == S_READ, state_r == S_EMIT,
                    "read not followed by emit")
  `DBQFP_ASSERT(a_cnt_range, state_r != S_IDLE, cnt_r <= RES_W'(FRAME_BYTES - 1),
                "frame byte count overran")

endmodule

>>> rtl/dbqfp_dpath.sv
// Datapath: shared byte store, queue pointers, counts, block locks, result register
`timescale 1ns / 1ps
`include "dual_byte_queue_frame_pop_core_defines.svh"
module dbqfp_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dbqfp_pkg::dbqfp_cmd_t            cmd,
  input  logic                             queue_sel,
  input  logic [dbqfp_pkg::BYTE_W-1:0]     data_byte,
  input  logic                             block_start,
  input  logic                             block_last,
  input  logic [dbqfp_pkg::LEN_W-1:0]      block_length,
  output dbqfp_pkg::dbqfp_stat_t           stat,
  output logic [1:0]                       status,
  output logic [dbqfp_pkg::BYTE_W-1:0]     frame_byte,
  output logic                             from_queue,
  output logic                             last
);
  import dbqfp_pkg::*;

  logic [BYTE_W-1:0] mem [2**ADDR_W];

  logic [IDX_W-1:0]  rd_idx_r [2];
  logic [IDX_W-1:0]  rd_idx_nxt [2];
  logic [IDX_W-1:0]  wr_idx_r [2];
  logic [IDX_W-1:0]  wr_idx_nxt [2];
  logic [FILL_W-1:0] fill_r [2];
  logic [FILL_W-1:0] fill_nxt [2];
  logic [RES_W-1:0]  res_r [2];
  logic [RES_W-1:0]  res_nxt [2];
  logic [1:0]        open_r, open_nxt;
  logic [1:0]        adm_r, adm_nxt;
  logic              q_r;
  logic [BYTE_W-1:0] rd_data_r;

  logic              open_eff;
  logic              adm_eff;
  logic              admit_ok;
  logic              wr_en;
  logic              pick_q;

  // modulo-frame residue tracks fill count so the pop check needs no divider
  function automatic logic [RES_W-1:0] res_inc(input logic [RES_W-1:0] v);
    res_inc = (v == RES_W'(FRAME_BYTES - 1)) ? '0 : v + RES_W'(1);
  endfunction

  function automatic logic [RES_W-1:0] res_dec(input logic [RES_W-1:0] v);
    res_dec = (v == '0) ? RES_W'(FRAME_BYTES - 1) : v - RES_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] v);
    idx_inc = (v == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : v + IDX_W'(1);
  endfunction

  assign admit_ok = (SUM_W'(fill_r[queue_sel]) + SUM_W'(block_length))
                    <= SUM_W'(QUEUE_DEPTH);
  assign open_eff = block_start || open_r[queue_sel];
  assign adm_eff  = block_start ? admit_ok : adm_r[queue_sel];
  assign wr_en    = cmd.push && open_eff && adm_eff &&
                    (fill_r[queue_sel] != FILL_W'(QUEUE_DEPTH));

  assign pick_q      = (fill_r[0] == '0);
  assign stat.empty  = (fill_r[0] == '0) && (fill_r[1] == '0);
  assign stat.refuse = open_r[pick_q] || (res_r[pick_q] != '0);

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    fill_nxt   = fill_r;
    res_nxt    = res_r;
    open_nxt   = open_r;
    adm_nxt    = adm_r;
    if (cmd.push && open_eff) begin
      open_nxt[queue_sel] = !block_last;
      adm_nxt[queue_sel]  = block_last ? 1'b0 : adm_eff;
    end
    if (wr_en) begin
      wr_idx_nxt[queue_sel] = idx_inc(wr_idx_r[queue_sel]);
      fill_nxt[queue_sel]   = fill_r[queue_sel] + FILL_W'(1);
      res_nxt[queue_sel]    = res_inc(res_r[queue_sel]);
    end
    if (cmd.rd_issue) begin
      rd_idx_nxt[q_r] = idx_inc(rd_idx_r[q_r]);
      fill_nxt[q_r]   = fill_r[q_r] - FILL_W'(1);
      res_nxt[q_r]    = res_dec(res_r[q_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '{default: '0};
      wr_idx_r <= '{default: '0};
      fill_r   <= '{default: '0};
      res_r    <= '{default: '0};
      open_r   <= '0;
      adm_r    <= '0;
      q_r      <= 1'b0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      fill_r   <= fill_nxt;
      res_r    <= res_nxt;
      open_r   <= open_nxt;
      adm_r    <= adm_nxt;
      if (cmd.pop_start) q_r <= pick_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[{queue_sel, wr_idx_r[queue_sel]}] <= data_byte;
    if (cmd.rd_issue) rd_data_r <= mem[{q_r, rd_idx_r[q_r]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= cmd.out_kind;
      frame_byte <= (cmd.out_kind == STAT_FRAME) ? rd_data_r : '0;
      case (cmd.out_kind)
        STAT_FRAME: from_queue <= q_r;
        STAT_ERROR: from_queue <= pick_q;
        default:    from_queue <= 1'b0;
      endcase
      last <= cmd.out_last;
    end
  end

  `DBQFP_ASSERT(a_fill_cap, 1'b1,
                (fill_r[0] <= FILL_W'(QUEUE_DEPTH)) && (fill_r[1] <= FILL_W'(QUEUE_DEPTH)),
                "queue fill beyond capacity")
  `DBQFP_ASSERT(a_read_nonempty, cmd.rd_issue, fill_r[q_r] != '0,
                "byte read from an empty queue")
  `DBQFP_ASSERT(a_push_read_excl, cmd.push, !cmd.rd_issue,
                "push during a frame read")

endmodule

>>> sim/tb.sv
// Self-checking testbench for the dual byte queue with prioritized frame pop
`timescale 1ns / 1ps
module tb;
  import dbqfp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 100;
  localparam int IDLE_PCT     = 8;
  localparam int MAX_PRINTS   = 30;

  typedef struct packed {
    dbqfp_op_t         op;
    logic              queue_sel;
    logic [BYTE_W-1:0] data_byte;
    logic              block_start;
    logic              block_last;
    logic [LEN_W-1:0]  block_length;
  } queue_cmd_t;

  typedef struct packed {
    dbqfp_status_t     status;
    logic [BYTE_W-1:0] frame_byte;
    logic              from_queue;
    logic              last;
  } pop_res_t;

  typedef struct packed {
    queue_cmd_t cmd;
    logic       fixed;
    pop_res_t   res;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;

  dbqfp_in_if  in_ch ();
  dbqfp_out_if out_ch ();

  dual_byte_queue_frame_pop_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of both queues
  logic [BYTE_W-1:0] mirror [2][QUEUE_DEPTH];
  int rd_ix [2];
  int wr_ix [2];
  int fill [2];
  bit locked [2];
  bit admitted [2];
  pop_res_t due_results [$];

  int errors;
  int cycles;
  int n_items;
  int n_frames;
  int n_empty;
  int n_refused;
  bit idle_on;
  logic cur_fixed;
  pop_res_t cur_res;

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, what);
  endtask

  // Advance the mirror by one accepted item and queue the results it causes.
  // A fixed row supplies its own expected result in place of the computed one.
  function automatic void queue_step(queue_cmd_t c, logic fixed, pop_res_t fixed_res);
    int q;
    pop_res_t r;
    if (c.op == CMD_PUSH) begin
      q = c.queue_sel;
      if (c.block_start) begin
        locked[q] = 1'b1;
        admitted[q] = (fill[q] + int'(c.block_length)) <= QUEUE_DEPTH;
      end
      if (locked[q]) begin
        if (admitted[q] && fill[q] < QUEUE_DEPTH) begin
          mirror[q][wr_ix[q]] = c.data_byte;
          wr_ix[q] = (wr_ix[q] + 1) % QUEUE_DEPTH;
          fill[q]++;
        end
        if (c.block_last) begin
          locked[q] = 1'b0;
          admitted[q] = 1'b0;
        end
      end
      return;
    end
    r = '0;
    r.last = 1'b1;
    if (fill[0] == 0 && fill[1] == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      q = (fill[0] != 0) ? 0 : 1;
      r.from_queue = q[0];
      if (locked[q] || (fill[q] % FRAME_BYTES) != 0) begin
        r.status = STAT_ERROR;
      end else begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
          r.status = STAT_FRAME;
          r.frame_byte = mirror[q][rd_ix[q]];
          r.last = (i == FRAME_BYTES - 1);
          rd_ix[q] = (rd_ix[q] + 1) % QUEUE_DEPTH;
          fill[q]--;
          if (!fixed) due_results.push_back(r);
        end
      end
    end
    if (fixed) due_results.push_back(fixed_res);
    else if (r.status != STAT_FRAME) due_results.push_back(r);
  endfunction

  function automatic queue_cmd_t rand_cmd(dbqfp_op_t op);
    queue_cmd_t c;
    c.op = op;
    c.queue_sel = 1'($urandom_range(1));
    c.data_byte = BYTE_W'($urandom_range(255));
    c.block_start = 1'($urandom_range(1));
    c.block_last = 1'($urandom_range(1));
    c.block_length = LEN_W'($urandom_range(511));
    return c;
  endfunction

  function automatic step_row_t step_row(dbqfp_op_t op, bit qs, logic [BYTE_W-1:0] db,
                                         bit st, bit ls, int len, bit fixed,
                                         dbqfp_status_t stat, bit fq);
    step_row_t r;
    r.cmd.op = op;
    r.cmd.queue_sel = qs;
    r.cmd.data_byte = db;
    r.cmd.block_start = st;
    r.cmd.block_last = ls;
    r.cmd.block_length = len[LEN_W-1:0];
    r.fixed = fixed;
    r.res.status = stat;
    r.res.frame_byte = '0;
    r.res.from_queue = fq;
    r.res.last = 1'b1;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(queue_cmd_t c, logic fixed = 1'b0, pop_res_t fixed_res = '0);
    bit counts;
    counts = (c.op == CMD_POP) || c.block_start || locked[c.queue_sel];
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.command = c.op;
    in_ch.queue_sel = c.queue_sel;
    in_ch.data_byte = c.data_byte;
    in_ch.block_start = c.block_start;
    in_ch.block_last = c.block_last;
    in_ch.block_length = c.block_length;
    cur_fixed = fixed;
    cur_res = fixed_res;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (counts) n_items++;
  endtask

  // One push block, with an occasional pop slipped in while it is open
  task automatic send_block(int q, int nbytes, int decl);
    queue_cmd_t c;
    for (int k = 0; k < nbytes; k++) begin
      if (k > 0 && $urandom_range(99) < 4) send_item(rand_cmd(CMD_POP));
      c.op = CMD_PUSH;
      c.queue_sel = q[0];
      c.data_byte = BYTE_W'($urandom_range(255));
      c.block_start = (k == 0);
      c.block_last = (k == nbytes - 1);
      c.block_length = (k == 0) ? decl[LEN_W-1:0] : LEN_W'($urandom_range(511));
      send_item(c);
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready = !(idle_on && $urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    pop_res_t seen;
    pop_res_t want;
    queue_cmd_t taken;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.status = dbqfp_status_t'(out_ch.status);
        seen.frame_byte = out_ch.frame_byte;
        seen.from_queue = out_ch.from_queue;
        seen.last = out_ch.last;
        if (seen.last) begin
          case (seen.status)
            STAT_FRAME: n_frames++;
            STAT_EMPTY: n_empty++;
            default:    n_refused++;
          endcase
        end
        if (due_results.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = due_results.pop_front();
          if (seen.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", seen.status, want.status));
          if (seen.frame_byte !== want.frame_byte)
            report_mismatch($sformatf("frame_byte got %02h want %02h",
                                      seen.frame_byte, want.frame_byte));
          if (seen.from_queue !== want.from_queue)
            report_mismatch($sformatf("from_queue got %0d want %0d",
                                      seen.from_queue, want.from_queue));
          if (seen.last !== want.last)
            report_mismatch($sformatf("last got %0d want %0d", seen.last, want.last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        taken.op = dbqfp_op_t'(in_ch.command);
        taken.queue_sel = in_ch.queue_sel;
        taken.data_byte = in_ch.data_byte;
        taken.block_start = in_ch.block_start;
        taken.block_last = in_ch.block_last;
        taken.block_length = in_ch.block_length;
        queue_step(taken, cur_fixed, cur_res);
      end
    end
  end

  initial begin : stimulus
    step_row_t steps [$];
    queue_cmd_t c;
    int q;
    int base;
    int len;
    int decl;
    int pick;
    int rand_from;
    bit drained;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_PUSH;
    in_ch.queue_sel = 1'b0;
    in_ch.data_byte = '0;
    in_ch.block_start = 1'b0;
    in_ch.block_last = 1'b0;
    in_ch.block_length = '0;
    out_ch.ready = 1'b1;
    cur_fixed = 1'b0;
    cur_res = '0;
    idle_on = 1'b1;
    drained = 1'b0;
    for (int i = 0; i < 2; i++) begin
      rd_ix[i] = 0;
      wr_ix[i] = 0;
      fill[i] = 0;
      locked[i] = 1'b0;
      admitted[i] = 1'b0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // op, queue, byte, start, last, length, fixed, status, from_queue
    steps.push_back(step_row(CMD_POP,  1, 8'hFF, 1, 1, 511, 1, STAT_EMPTY, 0));
    steps.push_back(step_row(CMD_PUSH, 0, 8'hFF, 0, 1, 0,   0, STAT_FRAME, 0)); // stray
    steps.push_back(step_row(CMD_POP,  0, 8'h00, 0, 0, 0,   1, STAT_EMPTY, 0));
    steps.push_back(step_row(CMD_PUSH, 0, 8'hA5, 1, 1, 1,   0, STAT_FRAME, 0)); // one byte
    steps.push_back(step_row(CMD_POP,  0, 8'h00, 0, 0, 0,   1, STAT_ERROR, 0)); // misaligned
    steps.push_back(step_row(CMD_PUSH, 0, 8'h00, 1, 0, 256, 0, STAT_FRAME, 0)); // too long
    steps.push_back(step_row(CMD_PUSH, 0, 8'h11, 0, 0, 0,   0, STAT_FRAME, 0)); // dropped
    steps.push_back(step_row(CMD_POP,  0, 8'h00, 0, 0, 0,   1, STAT_ERROR, 0)); // locked
    steps.push_back(step_row(CMD_PUSH, 0, 8'hFF, 1, 0, 10,  0, STAT_FRAME, 0)); // restart
    steps.push_back(step_row(CMD_PUSH, 0, 8'h01, 0, 0, 0,   0, STAT_FRAME, 0));
    steps.push_back(step_row(CMD_PUSH, 0, 8'h02, 0, 0, 0,   0, STAT_FRAME, 0));
    steps.push_back(step_row(CMD_PUSH, 0, 8'h04, 0, 0, 0,   0, STAT_FRAME, 0));
    steps.push_back(step_row(CMD_PUSH, 0, 8'h08, 0, 0, 0,   0, STAT_FRAME, 0));
    steps.push_back(step_row(CMD_PUSH, 0, 8'h10, 0, 0, 0,   0, STAT_FRAME, 0));
    steps.push_back(step_row(CMD_PUSH, 0, 8'h20, 0, 0, 0,   0, STAT_FRAME, 0));
    steps.push_back(step_row(CMD_PUSH, 0, 8'h40, 0, 0, 0,   0, STAT_FRAME, 0));
    steps.push_back(step_row(CMD_PUSH, 0, 8'h80, 0, 0, 0,   0, STAT_FRAME, 0));
    steps.push_back(step_row(CMD_PUSH, 0, 8'h7E, 0, 1, 0,   0, STAT_FRAME, 0));
    steps.push_back(step_row(CMD_POP,  0, 8'h00, 0, 0, 0,   0, STAT_FRAME, 0)); // full frame
    steps.push_back(step_row(CMD_PUSH, 1, 8'h3C, 1, 0, 256, 0, STAT_FRAME, 0));
    steps.push_back(step_row(CMD_POP,  0, 8'h00, 0, 0, 0,   1, STAT_ERROR, 1)); // B locked
    steps.push_back(step_row(CMD_PUSH, 1, 8'hC3, 0, 1, 0,   0, STAT_FRAME, 0));
    steps.push_back(step_row(CMD_POP,  0, 8'h00, 0, 0, 0,   1, STAT_ERROR, 1));
    steps.push_back(step_row(CMD_PUSH, 1, 8'h01, 1, 1, 0,   0, STAT_FRAME, 0)); // zero length
    steps.push_back(step_row(CMD_POP,  0, 8'h00, 0, 0, 0,   1, STAT_ERROR, 1));
    foreach (steps[i]) send_item(steps[i].cmd, steps[i].fixed, steps[i].res);

    // random part: first stretch runs without idling on either side
    idle_on = 1'b0;
    rand_from = n_items;
    while (n_items - rand_from < RANDOM_ITEMS) begin
      if (n_items - rand_from > 50) idle_on = 1'b1;
      if (!drained && n_items - rand_from > 70) begin
        drained = 1'b1;
        in_ch.valid = 1'b0;
        while (due_results.size() != 0) @(negedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
        // block sized to leave the queue on a frame boundary
        q = $urandom_range(1);
        base = (FRAME_BYTES - fill[q] % FRAME_BYTES) % FRAME_BYTES;
        len = base + FRAME_BYTES * $urandom_range(0, 2);
        if (len == 0) len = FRAME_BYTES;
        decl = ($urandom_range(9) == 0) ? $urandom_range(len, 511) : len;
        send_block(q, len, decl);
      end else if (pick < 85) begin
        send_item(rand_cmd(CMD_POP));
      end else begin
        c = rand_cmd(CMD_PUSH);
        if ($urandom_range(1)) c.block_start = 1'b0;
        send_item(c);
      end
    end

    // admitted block that runs past a full queue; leaves it misaligned, so last
    q = (fill[1] >= fill[0]) ? 1 : 0;
    send_block(q, QUEUE_DEPTH - fill[q] + 3, QUEUE_DEPTH - fill[q]);
    repeat (3) send_item(rand_cmd(CMD_POP));
    in_ch.valid = 1'b0;

    while (due_results.size() != 0) @(negedge clk);
    repeat (2 * FRAME_BYTES + 10) @(posedge clk);

    $display("Covered %0d items: %0d frame pops, %0d empty pops, %0d refused pops",
             n_items, n_frames, n_empty, n_refused);
    $display("Bytes left queued: A %0d, B %0d; mismatches %0d", fill[0], fill[1], errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
